/* hdl/swrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window rank select filter.
// Used by swrs_ctrl, swrs_dp and sliding_window_rank_select; no dependencies.
package swrs_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W_DEF   = 32;
  localparam int CFG_W          = 7;
  localparam int RANK_W         = 7;
  localparam int OUT_W          = 32;
  localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_SELECT
  } swrs_state_t;

  // controller -> datapath
  typedef struct packed {
    logic             accept;    // shift the new sample into the sorted cells
    logic             prefix;    // capture first half of the window prefix count
    logic             load_out;  // load the result register
    logic             err;       // result carries a rank error
    logic [CFG_W-1:0] w_eff;     // effective window size, 1..WINDOW_MAX
  } swrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rank_bad;
  } swrs_stat_t;

endpackage

/* hdl/swrs_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the rank select filter: handshakes, window size register,
// fill count and the per-word sequence. Depends on swrs_pkg.
module swrs_ctrl
  import swrs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  swrs_stat_t       stat,
  output swrs_cmd_t        cmd
);

  localparam int CW = $clog2(WINDOW_MAX + 1);

  swrs_state_t      state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt, fill_inc;
  logic [CFG_W-1:0] win_r, w_eff;
  logic             out_valid_r, out_valid_nxt;
  logic             err_r, err_nxt;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;

  always_comb begin
    if (win_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (int'(win_r) > WINDOW_MAX) begin
      w_eff = CFG_W'(WINDOW_MAX);
    end else begin
      w_eff = win_r;
    end
  end

  // saturate at the store depth
  assign fill_inc = (fill_r == CW'(WINDOW_MAX)) ? fill_r : fill_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      win_r       <= CFG_W'(1);
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        win_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    err_nxt      = err_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.prefix   = 1'b0;
    cmd.load_out = 1'b0;
    cmd.err      = err_r;
    cmd.w_eff    = w_eff;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          fill_nxt   = fill_inc;
          err_nxt    = stat.rank_bad;
          // no result until the window is full
          if (int'(fill_inc) >= int'(w_eff)) begin
            state_nxt = ST_PREFIX;
          end
        end
      end
      ST_PREFIX: begin
        cmd.prefix = 1'b1;
        state_nxt  = ST_SELECT;
      end
      ST_SELECT: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_MAX)
    else $error("fill count above store depth");

  a_weff_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_eff != '0 && int'(w_eff) <= WINDOW_MAX)
    else $error("effective window size out of range");

  a_prefix_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PREFIX |-> $past(in_tvalid && in_tready))
    else $error("prefix step without an accepted word");

  a_select_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SELECT && !out_valid_r) |=> out_valid_r)
    else $error("free result register not loaded in select step");
`endif

endmodule

/* hdl/swrs_dp.sv */
`timescale 1ns / 1ps
// Datapath for the rank select filter: sorted sample cells with ages, a two-step
// prefix count of in-window cells, rank match and the result register. Uses swrs_pkg.
module swrs_dp
  import swrs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SAMPLE_W   = SAMPLE_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [RANK_W-1:0]   rank_in,
  input  swrs_cmd_t           cmd,
  output swrs_stat_t          stat,
  output logic [OUT_W-1:0]    out_value,
  output logic                out_err
);

  localparam int N  = WINDOW_MAX;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int L  = $clog2(N);
  localparam int LA = (L + 1) / 2;
  localparam int LB = L - LA;

  // sorted cells, ascending by signed value
  logic [SAMPLE_W-1:0] val_r [N];
  logic [AW-1:0]       age_r [N];
  logic [N-1:0]        v_r;

  logic [SAMPLE_W-1:0] val_nxt [N];
  logic [AW-1:0]       age_nxt [N];
  logic [N-1:0]        v_nxt;

  logic [SAMPLE_W-1:0] xval [N+1];
  logic [AW-1:0]       xage [N+1];
  logic [N:0]          xv;
  logic [N:0]          lt;
  logic [N-1:0]        d;
  logic [N-1:0]        rb;
  logic [SAMPLE_W-1:0] cval [N];
  logic [AW-1:0]       cage [N];
  logic [N-1:0]        cv;
  logic [N-1:0]        ltc;

  logic [RANK_W-1:0]   rank_r;
  logic [N-1:0]        m;
  logic [CW-1:0]       ka [LA+1][N];
  logic [CW-1:0]       pa_r [N];
  logic [CW-1:0]       kb [LB+1][N];
  logic [N-1:0]        hit;
  logic [SAMPLE_W-1:0] sel;
  logic [OUT_W+SAMPLE_W-1:0] ext;
  logic [OUT_W-1:0]    out_value_r;
  logic                out_err_r;

  assign stat.rank_bad = (rank_in == '0) || (int'(rank_in) > int'(cmd.w_eff));

  assign xval[N] = '0;
  assign xage[N] = '0;
  assign xv[N]   = 1'b0;
  assign lt[N]   = 1'b0;

  for (genvar j = 0; j < N; j++) begin : g_cell
    assign xval[j] = val_r[j];
    assign xage[j] = age_r[j];
    assign xv[j]   = v_r[j];
    assign lt[j]   = v_r[j] && ($signed(val_r[j]) < $signed(sample_in));
    // oldest sample leaves when the store is full
    assign d[j]    = v_r[j] && (age_r[j] == AW'(N - 1));
    assign rb[j]   = |d[j:0];

    // close the gap left by the removed cell
    assign cval[j] = rb[j] ? xval[j+1] : xval[j];
    assign cage[j] = rb[j] ? xage[j+1] : xage[j];
    assign cv[j]   = rb[j] ? xv[j+1]   : xv[j];
    assign ltc[j]  = rb[j] ? lt[j+1]   : lt[j];

    if (j == 0) begin : g_first
      always_comb begin
        if (ltc[j]) begin
          val_nxt[j] = cval[j];
          age_nxt[j] = cage[j] + AW'(1);
          v_nxt[j]   = cv[j];
        end else begin
          val_nxt[j] = sample_in;
          age_nxt[j] = '0;
          v_nxt[j]   = 1'b1;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (ltc[j]) begin
          val_nxt[j] = cval[j];
          age_nxt[j] = cage[j] + AW'(1);
          v_nxt[j]   = cv[j];
        end else if (ltc[j-1]) begin
          val_nxt[j] = sample_in;
          age_nxt[j] = '0;
          v_nxt[j]   = 1'b1;
        end else begin
          val_nxt[j] = cval[j-1];
          age_nxt[j] = cage[j-1] + AW'(1);
          v_nxt[j]   = cv[j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (cmd.accept) begin
        v_r[j] <= v_nxt[j];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.accept) begin
        val_r[j] <= val_nxt[j];
        age_r[j] <= age_nxt[j];
      end
    end

    // in-window membership: the w_eff newest samples
    assign m[j]     = v_r[j] && (int'(age_r[j]) < int'(cmd.w_eff));
    assign ka[0][j] = CW'(m[j]);
  end

  // inclusive prefix count of m, first half of the levels
  for (genvar k = 0; k < LA; k++) begin : g_lva
    for (genvar j = 0; j < N; j++) begin : g_c
      if (j >= (1 << k)) begin : g_add
        assign ka[k+1][j] = ka[k][j] + ka[k][j-(1<<k)];
      end else begin : g_pass
        assign ka[k+1][j] = ka[k][j];
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_pa
    always_ff @(posedge clk) begin
      if (cmd.prefix) begin
        pa_r[j] <= ka[LA][j];
      end
    end
    assign kb[0][j] = pa_r[j];
  end

  // remaining levels
  for (genvar k = 0; k < LB; k++) begin : g_lvb
    for (genvar j = 0; j < N; j++) begin : g_c
      if (j >= (1 << (LA + k))) begin : g_add
        assign kb[k+1][j] = kb[k][j] + kb[k][j-(1<<(LA+k))];
      end else begin : g_pass
        assign kb[k+1][j] = kb[k][j];
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_hit
    assign hit[j] = m[j] && (int'(kb[LB][j]) == int'(rank_r));
  end

  always_comb begin
    sel = '0;
    for (int j = 0; j < N; j++) begin
      sel = sel | (hit[j] ? val_r[j] : '0);
    end
  end

  assign ext = {{OUT_W{1'b0}}, sel};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rank_r <= rank_in;
    end
    if (cmd.load_out) begin
      out_value_r <= cmd.err ? '0 : ext[OUT_W-1:0];
      out_err_r   <= cmd.err;
    end
  end

  assign out_value = out_value_r;
  assign out_err   = out_err_r;

`ifndef NO_ASSERTIONS
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && !cmd.err) |-> $onehot(hit))
    else $error("rank match is not unique");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, v_r} + {{N{1'b0}}, 1'b1}))
    else $error("valid cells not packed at the low end");

  a_cells_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prefix |=> $stable(v_r))
    else $error("cells changed during rank selection");
`endif

endmodule

/* hdl/sliding_window_rank_select.sv */
`timescale 1ns / 1ps
// Sliding-window rank select: top level, joins controller and datapath. Uses swrs_pkg.
// A word that fills the window passes the insert, prefix and select steps; out_tvalid
// rises once the select step has loaded the result register, and the next word is taken
// only after that. The select step holds while an earlier result still waits on out_tready.
// A word while the window is still filling takes only the insert step and gives no result.
// rst_n (synchronous, active low) empties the window and sets window_size to 1.
module sliding_window_rank_select
  import swrs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SAMPLE_W   = SAMPLE_W_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // [SAMPLE_W-1:0] sample_value, [SAMPLE_W+6:SAMPLE_W] rank_wanted, zero fill above
  input  logic [((SAMPLE_W + RANK_W + 7) / 8) * 8-1:0] in_tdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // [31:0] selected_value
  output logic [OUT_TDATA_W-1:0]                   out_tdata,
  // [0] rank_error
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  input  logic [CFG_W-1:0]                         cfg_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready
);

  swrs_cmd_t        cmd;
  swrs_stat_t       stat;
  logic [OUT_W-1:0] out_value;

  swrs_ctrl #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  swrs_dp #(
    .WINDOW_MAX(WINDOW_MAX),
    .SAMPLE_W  (SAMPLE_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample_in(in_tdata[SAMPLE_W-1:0]),
    .rank_in  (in_tdata[SAMPLE_W +: RANK_W]),
    .cmd      (cmd),
    .stat     (stat),
    .out_value(out_value),
    .out_err  (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(out_value);

endmodule

/* bench/swrs_checker.sv */
`timescale 1ns / 1ps
// Rank-select checker: watches the sample, result and window-size channels of
// sliding_window_rank_select, predicts each result and compares. Uses swrs_pkg.
module swrs_checker
  import swrs_pkg::*;
#(
  parameter int IN_TDATA_W = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    fail_count,
  output int                    pending
);

  typedef logic signed [SAMPLE_W_DEF-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    rank_err;
  } rank_pick_t;

  sample_t          recent[WINDOW_MAX_DEF];
  int               wr_slot;
  int               stored_cnt;
  logic [CFG_W-1:0] win_size_reg;
  rank_pick_t       expected_picks[$];
  int               reported;

  // Store the sample, then pick the rank-th smallest of the newest samples.
  function automatic bit take_sample(input sample_t smp, input logic [RANK_W-1:0] rank,
                                     output rank_pick_t pick);
    sample_t sorted[WINDOW_MAX_DEF];
    sample_t hold;
    int      span;
    int      a;
    int      b;
    span = (win_size_reg == 0) ? 1 :
           (win_size_reg > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(win_size_reg);
    recent[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % WINDOW_MAX_DEF;
    if (stored_cnt < WINDOW_MAX_DEF) stored_cnt++;
    pick.value = '0;
    pick.rank_err = 1'b0;
    if (stored_cnt < span) return 1'b0;
    if (rank == 0 || rank > span) begin
      pick.rank_err = 1'b1;
      return 1'b1;
    end
    for (a = 0; a < span; a++) begin
      sorted[a] = recent[(wr_slot + WINDOW_MAX_DEF - 1 - a) % WINDOW_MAX_DEF];
    end
    // insertion sort, signed order
    for (a = 1; a < span; a++) begin
      hold = sorted[a];
      b = a - 1;
      while (b >= 0 && sorted[b] > hold) begin
        sorted[b + 1] = sorted[b];
        b--;
      end
      sorted[b + 1] = hold;
    end
    pick.value = sorted[rank - 1];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rank_pick_t pick;
    rank_pick_t want;
    sample_t    got_value;
    if (!rst_n) begin
      foreach (recent[k]) recent[k] = '0;
      wr_slot = 0;
      stored_cnt = 0;
      win_size_reg = 7'd1;
      expected_picks.delete();
      reported = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) win_size_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        if (take_sample(in_tdata[SAMPLE_W_DEF-1:0],
                        in_tdata[SAMPLE_W_DEF+RANK_W-1:SAMPLE_W_DEF], pick)) begin
          expected_picks.push_back(pick);
        end
      end
      if (out_tvalid && out_tready) begin
        got_value = out_tdata[SAMPLE_W_DEF-1:0];
        if (expected_picks.size() == 0) begin
          fail_count <= fail_count + 1;
          if (reported < 10) begin
            $display("unexpected result word: value %0d rank_error %0b", got_value, out_tuser);
          end
          reported++;
        end else begin
          want = expected_picks.pop_front();
          if (got_value !== want.value || out_tuser !== want.rank_err) begin
            fail_count <= fail_count + 1;
            if (reported < 10) begin
              $display("result mismatch: value exp %0d got %0d, rank_error exp %0b got %0b",
                       want.value, got_value, want.rank_err, out_tuser);
            end
            reported++;
          end
        end
      end
      pending <= expected_picks.size();
    end
  end

endmodule

/* bench/tb_sliding_window_rank_select.sv */
`timescale 1ns / 1ps
// Testbench top for sliding_window_rank_select: clock, reset, window-size writes,
// sample words in bursts and a stalling receiver. Uses swrs_pkg and swrs_checker.
module tb_sliding_window_rank_select;
  import swrs_pkg::*;

  localparam int IN_TDATA_W = ((SAMPLE_W_DEF + RANK_W + 7) / 8) * 8;
  localparam int LONG_HOLD  = 400;

  typedef logic signed [SAMPLE_W_DEF-1:0] sample_t;

  typedef struct {
    sample_t           sample;
    logic [RANK_W-1:0] rank;
  } sample_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  int                     fail_count;
  int                     pending;
  logic                   long_hold_go = 1'b0;

  sample_word_t batch[$];
  int           burst_left = 1;
  int           span_now = 1;

  always #1 clk = ~clk;

  sliding_window_rank_select u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  swrs_checker #(.IN_TDATA_W(IN_TDATA_W)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic void add_word(input sample_t s, input int r);
    sample_word_t w;
    w.sample = s;
    w.rank = RANK_W'(r);
    batch.push_back(w);
  endfunction

  function automatic sample_t rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return sample_t'($urandom_range(0, 15)) - 8;
    if (pick < 8) return sample_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // mostly legal ranks, the rest zero or past the window
  function automatic int rand_rank(input int span);
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, span);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(span + 1, 127);
  endfunction

  task automatic send_batch();
    int k;
    for (k = 0; k < batch.size(); k++) begin
      in_tdata <= {{(IN_TDATA_W - SAMPLE_W_DEF - RANK_W){1'b0}}, batch[k].rank, batch[k].sample};
      in_tvalid <= 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      burst_left--;
      // end the burst: drop valid for a gap
      if (burst_left <= 0 || k == batch.size() - 1) begin
        in_tvalid <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(8, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 4)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
    end
    batch.delete();
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input int v);
    cfg_data <= CFG_W'(v);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    span_now = (v == 0) ? 1 : (v > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : v;
    @(posedge clk);
  endtask

  task automatic random_phase(input int v, input int count);
    int k;
    write_window(v);
    for (k = 0; k < count; k++) add_word(rand_sample(), rand_rank(span_now));
    send_batch();
    drain();
  endtask

  // receiver: ready pattern changes per segment, plus one long hold-off
  initial begin : receiver
    int  seg_left;
    int  mode;
    int  tick;
    bit  hold_done;
    seg_left = 0;
    mode = 0;
    tick = 0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (tick % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : timeout
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of five filling from reset: four words give nothing
    write_window(5);
    add_word(32'sh7FFF_FFFF, 1);
    add_word(32'sh8000_0000, 2);
    add_word(-1, 3);
    add_word(0, 4);
    add_word(32'sh7FFF_FFFF, 5);
    add_word(-1, 1);
    add_word(5, 0);
    add_word(6, 6);
    add_word(7, 127);
    add_word(-1, 3);
    add_word(-1, 2);
    send_batch();
    drain();

    // size zero acts as one
    write_window(0);
    add_word(123, 1);
    add_word(-5, 2);
    add_word(32'sh5555_5555, 1);
    add_word(32'shAAAA_AAAA, 1);
    send_batch();
    drain();

    // largest setting above the limit, then the limit itself with a long stall
    random_phase(127, 70);
    long_hold_go <= 1'b1;
    add_word(32'sh7FFF_FFFF, 64);
    add_word(32'sh8000_0000, 1);
    add_word(-3, 65);
    random_phase(64, 40);
    random_phase(1, 40);
    random_phase(0, 30);
    random_phase(3, 40);
    random_phase(63, 40);
    random_phase(65, 30);
    v = $urandom_range(2, 127);
    random_phase(v, 40);
    v = $urandom_range(0, 127);
    random_phase(v, 40);
    random_phase(16, 40);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/swrs_pkg.sv
hdl/swrs_ctrl.sv
hdl/swrs_dp.sv
hdl/sliding_window_rank_select.sv
bench/swrs_checker.sv
bench/tb_sliding_window_rank_select.sv
